/* design/pse_pkg.sv */
// Shared types, constants and the quarter-wave cosine function for the periodic state estimator.
package pse_pkg;

    localparam int unsigned LEVEL_BIAS = 655;

    typedef enum logic [1:0] {
        REQ_LOAD_COMP = 2'd0,
        REQ_LOAD_FLIP = 2'd1,
        REQ_QUERY     = 2'd2,
        REQ_ADD       = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        REG_MEAN_LEVEL = 2'd0,
        REG_COMP_COUNT = 2'd1,
        REG_INIT_LEN   = 2'd2
    } t_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COMP_RD,
        ST_MUL,
        ST_DIV_REM,
        ST_DIV_FRAC,
        ST_COS,
        ST_ACC,
        ST_FLIP_RD,
        ST_FLIP_CMP,
        ST_FINISH,
        ST_OUT
    } t_state;

    // Divider control/status between sequencer and divider.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;

    // Quarter-wave cosine, Q30 argument in [0,1], Q15 result.
    function automatic logic [15:0] quarter_cos(input logic [63:0] u30);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] h;
        logic [63:0] t;
        x  = (u30 * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        h  = (64'd1 << 30) - x2 / 64'd90;
        h  = (64'd1 << 30) - ((x2 * h) >> 30) / 64'd56;
        h  = (64'd1 << 30) - ((x2 * h) >> 30) / 64'd30;
        h  = (64'd1 << 30) - ((x2 * h) >> 30) / 64'd12;
        t  = ((x2 * h) >> 30) / 64'd2;
        if (t >= (64'd1 << 30)) begin
            quarter_cos = 16'd0;
        end else begin
            x = (((64'd1 << 30) - t) + 64'd16384) >> 15;
            quarter_cos = x[15:0];
        end
    endfunction

endpackage

/* design/pse_ram.sv */
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* design/pse_div.sv */
// Radix-2 restoring divider: 64-bit dividend by 32-bit divisor, one bit a cycle.
module pse_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [63:0]            i_dividend,
    input  logic [31:0]            i_divisor,
    output pse_pkg::t_div_ctl      o_ctl,
    output logic [63:0]            o_quot,
    output logic [31:0]            o_rem
);
    logic [63:0] r_quot, n_quot;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_dvs;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] w_sh;

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_sh   = {r_rem[31:0], r_quot[63]};
        if (i_start) begin
            n_quot = i_dividend;
            n_rem  = '0;
            n_cnt  = 7'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_dvs}) begin
                n_rem  = w_sh - {1'b0, r_dvs};
                n_quot = {r_quot[62:0], 1'b1};
            end else begin
                n_rem  = w_sh;
                n_quot = {r_quot[62:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy;
    assign o_ctl.done  = r_done;
    assign o_quot      = r_quot;
    assign o_rem       = r_rem[31:0];
endmodule

/* design/periodic_state_estimator_core.sv */
// Top level of the periodic state estimator: sequencer, tables and APB port.
//
// The block evaluates a periodic binary-state model. Each beat on the input
// channel is one request: load a component, load a flip point, query at a
// timestamp, or add an observation at the current observed length. Every
// request gives exactly one result beat. A request is worked on alone; the
// input is not ready until its result has been taken. A load goes from the
// accepting cycle straight to the result state. A query or add works, for
// each component in use in turn, through one table read, one multiply, two
// passes of the shared one-bit-a-cycle 64/32 divider (freq*t mod L, then
// rem*65536 / L; these set the rate), one cosine lookup and one accumulate.
// With a zero observed length the divider is skipped. A query then scans
// the flip list, one read and one compare state per entry, up to the first
// entry above the timestamp. Cosine comes from a quarter-wave table plus
// quadrant symmetry. Component and flip storage sit in RAMs with registered
// read and need no clearing pass.
// Configuration registers: 0 mean_level, 1 component_count, 2 initial_length
// (writing it also reloads the observed length), at byte addresses 4*i.
module periodic_state_estimator_core #(
    parameter int MAX_COMPONENTS = 16,
    parameter int MAX_FLIPS      = 256,
    parameter int COS_TABLE_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_entry_index,
    input  logic [15:0] i_amplitude,
    input  logic [15:0] i_phase,
    input  logic [15:0] i_frequency,
    input  logic [31:0] i_time_value,
    input  logic        i_observation,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [16:0] o_probability,
    output logic        o_state_bit,
    output logic        o_list_full,
    output logic        o_flip_added
);
    localparam int CW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int FW = $clog2(MAX_FLIPS);
    localparam int CNTW = $clog2(MAX_FLIPS + 1);
    localparam int NCW = $clog2(MAX_COMPONENTS + 1);
    localparam int QTR = 1 << (COS_TABLE_BITS - 2);
    localparam int QW = COS_TABLE_BITS - 1;

    // quarter-wave cosine table, entries 0..QTR inclusive, constant logic
    logic [15:0] w_qcos [QTR+1];
    for (genvar k = 0; k <= QTR; k++) begin : g_cos
        assign w_qcos[k] = pse_pkg::quarter_cos(64'(k) << (32 - COS_TABLE_BITS));
    end

    // configuration registers
    logic [15:0] r_mean_level;
    logic [4:0]  r_comp_count;
    logic [31:0] r_init_len;
    logic        w_cfg_wr;
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[3:2])
            pse_pkg::REG_MEAN_LEVEL: prdata = {16'd0, r_mean_level};
            pse_pkg::REG_COMP_COUNT: prdata = {27'd0, r_comp_count};
            pse_pkg::REG_INIT_LEN:   prdata = r_init_len;
            default:                 prdata = 32'd0;
        endcase
    end

    // state
    pse_pkg::t_state r_st, n_st;
    logic [1:0]   r_req;
    logic [31:0]  r_t;
    logic         r_obs;
    logic [31:0]  r_len;
    logic [CNTW-1:0] r_fcnt;
    logic [NCW-1:0]  r_idx;
    logic [NCW-1:0]  w_ncomp;
    logic [CNTW-1:0] r_scan;
    logic signed [47:0] r_sum;
    logic [47:0]  r_comp;
    logic [47:0]  r_prod;
    logic [31:0]  r_frac;
    logic signed [33:0] r_term;
    logic [16:0]  r_prob;

    assign w_ncomp = (r_comp_count > 5'(MAX_COMPONENTS)) ? NCW'(MAX_COMPONENTS)
                                                          : NCW'(r_comp_count);

    // memories
    logic [47:0] w_comp_rd;
    logic [31:0] w_flip_rd;
    logic        w_comp_we, w_flip_we;
    logic [31:0] w_flip_wd;
    logic [CW-1:0] w_comp_raddr;

    // registered read: address slot 0 at accept, the next slot at accumulate
    assign w_comp_raddr = (r_st == pse_pkg::ST_IDLE) ? '0 :
                          (r_st == pse_pkg::ST_ACC)  ? r_idx[CW-1:0] + CW'(1) :
                                                       r_idx[CW-1:0];

    pse_ram #(.WIDTH(48), .DEPTH(1 << CW)) u_comp_ram (
        .i_clk  (i_clk),
        .i_we   (w_comp_we),
        .i_waddr(CW'(i_entry_index)),
        .i_wdata({i_amplitude, i_phase, i_frequency}),
        .i_raddr(w_comp_raddr),
        .o_rdata(w_comp_rd)
    );

    pse_ram #(.WIDTH(32), .DEPTH(MAX_FLIPS)) u_flip_ram (
        .i_clk  (i_clk),
        .i_we   (w_flip_we),
        .i_waddr(r_fcnt[FW-1:0]),
        .i_wdata(w_flip_wd),
        .i_raddr(r_scan[FW-1:0]),
        .o_rdata(w_flip_rd)
    );

    // divider
    pse_pkg::t_div_ctl w_div;
    logic        w_div_start;
    logic [63:0] w_div_a, w_div_q;
    logic [31:0] w_div_r;
    pse_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_dividend(w_div_a),
        .i_divisor (r_len),
        .o_ctl     (w_div),
        .o_quot    (w_div_q),
        .o_rem     (w_div_r)
    );

    logic w_in_acc, w_out_acc;
    assign o_ready   = (r_st == pse_pkg::ST_IDLE);
    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;
    assign o_valid   = (r_st == pse_pkg::ST_OUT);

    // angle index from turn fraction plus phase
    logic [15:0] w_ang;
    assign w_ang = r_frac[15:0] + r_comp[31:16];

    // cosine by quadrant: mirror in quarters 1 and 3, negate in quarters 1 and 2
    logic [COS_TABLE_BITS-1:0] w_cidx;
    logic [QW-1:0]             w_qidx;
    logic [15:0]               w_cmag;
    logic signed [16:0]        w_cos;
    always_comb begin
        w_cidx = w_ang[15 -: COS_TABLE_BITS];
        if (w_cidx[COS_TABLE_BITS-2]) begin
            w_qidx = QW'(QTR) - {1'b0, w_cidx[COS_TABLE_BITS-3:0]};
        end else begin
            w_qidx = {1'b0, w_cidx[COS_TABLE_BITS-3:0]};
        end
        w_cmag = w_qcos[w_qidx];
        if (w_cidx[COS_TABLE_BITS-1] ^ w_cidx[COS_TABLE_BITS-2]) begin
            w_cos = -$signed({1'b0, w_cmag});
        end else begin
            w_cos = $signed({1'b0, w_cmag});
        end
    end

    // add: prediction (rounded p > 32768) taken from the final sum
    logic w_pred_gt, w_add_mis;
    assign w_pred_gt = (r_sum >= 48'sd536879104);
    assign w_add_mis = (w_pred_gt ^ r_fcnt[0]) != r_obs;

    // next-state logic
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            pse_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (i_req_type == pse_pkg::REQ_QUERY ||
                        i_req_type == pse_pkg::REQ_ADD) begin
                        n_st = pse_pkg::ST_COMP_RD;
                    end else begin
                        n_st = pse_pkg::ST_OUT;
                    end
                end
            end
            pse_pkg::ST_COMP_RD: begin
                n_st = (r_idx == w_ncomp) ? pse_pkg::ST_FINISH : pse_pkg::ST_MUL;
            end
            pse_pkg::ST_MUL: n_st = (r_len == 32'd0) ? pse_pkg::ST_COS
                                                     : pse_pkg::ST_DIV_REM;
            pse_pkg::ST_DIV_REM:  if (w_div.done) n_st = pse_pkg::ST_DIV_FRAC;
            pse_pkg::ST_DIV_FRAC: if (w_div.done) n_st = pse_pkg::ST_COS;
            pse_pkg::ST_COS:      n_st = pse_pkg::ST_ACC;
            pse_pkg::ST_ACC:      n_st = pse_pkg::ST_COMP_RD;
            pse_pkg::ST_FINISH: begin
                n_st = (r_req == pse_pkg::REQ_QUERY) ? pse_pkg::ST_FLIP_RD
                                                     : pse_pkg::ST_OUT;
            end
            pse_pkg::ST_FLIP_RD: begin
                n_st = (r_scan == r_fcnt) ? pse_pkg::ST_OUT : pse_pkg::ST_FLIP_CMP;
            end
            pse_pkg::ST_FLIP_CMP: begin
                n_st = (r_t < w_flip_rd) ? pse_pkg::ST_OUT : pse_pkg::ST_FLIP_RD;
            end
            pse_pkg::ST_OUT: if (i_ready) n_st = pse_pkg::ST_IDLE;
            default: n_st = pse_pkg::ST_IDLE;
        endcase
    end

    // output/control logic
    always_comb begin
        w_div_start = 1'b0;
        w_div_a     = 64'd0;
        w_comp_we   = 1'b0;
        w_flip_we   = 1'b0;
        w_flip_wd   = r_len;
        unique case (r_st)
            pse_pkg::ST_IDLE: begin
                w_comp_we = w_in_acc && (i_req_type == pse_pkg::REQ_LOAD_COMP) &&
                            ({1'b0, i_entry_index} < 5'(MAX_COMPONENTS));
                w_flip_we = w_in_acc && (i_req_type == pse_pkg::REQ_LOAD_FLIP) &&
                            (r_fcnt < CNTW'(MAX_FLIPS));
                w_flip_wd = i_time_value;
            end
            pse_pkg::ST_MUL: begin
                w_div_start = (r_len != 32'd0);
                w_div_a     = {16'd0, r_prod};
            end
            pse_pkg::ST_DIV_REM: begin
                w_div_start = w_div.done;
                w_div_a     = {16'd0, w_div_r, 16'd0};
            end
            pse_pkg::ST_FINISH: begin
                w_flip_we = (r_req == pse_pkg::REQ_ADD) && w_add_mis &&
                            (r_fcnt < CNTW'(MAX_FLIPS));
            end
            default: ;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st         <= pse_pkg::ST_IDLE;
            r_mean_level <= 16'd0;
            r_comp_count <= 5'd0;
            r_init_len   <= 32'd1;
            r_len        <= 32'd1;
            r_fcnt       <= '0;
        end else begin
            r_st <= n_st;
            if (w_cfg_wr) begin
                unique case (paddr[3:2])
                    pse_pkg::REG_MEAN_LEVEL: r_mean_level <= pwdata[15:0];
                    pse_pkg::REG_COMP_COUNT: r_comp_count <= pwdata[4:0];
                    pse_pkg::REG_INIT_LEN: begin
                        r_init_len <= pwdata;
                        r_len      <= pwdata;
                    end
                    default: ;
                endcase
            end
            if (w_flip_we) begin
                r_fcnt <= r_fcnt + CNTW'(1);
            end
            if (r_st == pse_pkg::ST_FINISH && r_req == pse_pkg::REQ_ADD) begin
                r_len <= r_len + 32'd1;
            end
        end

        unique case (r_st)
            pse_pkg::ST_IDLE: begin
                r_req   <= i_req_type;
                r_obs   <= i_observation;
                r_t     <= (i_req_type == pse_pkg::REQ_ADD) ? r_len : i_time_value;
                r_idx   <= '0;
                r_scan  <= '0;
                r_sum   <= 48'(($signed({1'b0, r_mean_level}) -
                                17'sd655)) <<< 14;
                r_prob  <= 17'd0;
            end
            pse_pkg::ST_COMP_RD: begin
                r_comp <= w_comp_rd;
                r_prod <= 48'(w_comp_rd[15:0]) * 48'(r_t);
                r_frac <= 32'd0;
            end
            pse_pkg::ST_DIV_FRAC: if (w_div.done) r_frac <= w_div_q[31:0];
            pse_pkg::ST_COS: begin
                r_term <= $signed({1'b0, r_comp[47:32]}) * w_cos;
            end
            pse_pkg::ST_ACC: begin
                r_sum <= r_sum + 48'(r_term);
                r_idx <= r_idx + NCW'(1);
            end
            pse_pkg::ST_FINISH: begin
                if (r_sum <= 48'sd0) begin
                    r_prob <= 17'd0;
                end else if (r_sum >= 48'sd1073741824) begin
                    r_prob <= 17'd65536;
                end else begin
                    r_prob <= 17'((r_sum + 48'sd8192) >>> 14);
                end
            end
            pse_pkg::ST_FLIP_CMP: begin
                if (!(r_t < w_flip_rd)) r_scan <= r_scan + CNTW'(1);
            end
            default: ;
        endcase
    end

    // add: pending flag registered from the FINISH state of an add
    logic r_add_pend;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add_pend <= 1'b0;
        end else begin
            r_add_pend <= (r_st == pse_pkg::ST_FINISH) && (r_req == pse_pkg::REQ_ADD);
        end
    end

    logic r_o_bit, r_o_full, r_o_added;
    always_ff @(posedge i_clk) begin
        if (r_st == pse_pkg::ST_IDLE) begin
            r_o_full  <= (i_req_type == pse_pkg::REQ_LOAD_FLIP) &&
                         (r_fcnt >= CNTW'(MAX_FLIPS));
            r_o_added <= 1'b0;
        end else if (r_st == pse_pkg::ST_FINISH && r_req == pse_pkg::REQ_ADD) begin
            r_o_bit   <= w_pred_gt ^ r_fcnt[0];
            r_o_full  <= w_add_mis && (r_fcnt >= CNTW'(MAX_FLIPS));
            r_o_added <= w_add_mis && (r_fcnt < CNTW'(MAX_FLIPS));
        end else if (r_st == pse_pkg::ST_FINISH) begin
            r_o_bit <= r_sum >= 48'sd536862720; // rounded p >= 32768
        end
    end

    assign o_probability = r_prob;
    assign o_state_bit   = (r_req == pse_pkg::REQ_LOAD_COMP ||
                            r_req == pse_pkg::REQ_LOAD_FLIP) ? 1'b0 :
                           (r_req == pse_pkg::REQ_ADD) ? r_o_bit :
                           (r_o_bit ^ r_scan[0]);
    assign o_list_full   = r_o_full;
    assign o_flip_added  = r_o_added;

    // flip count never exceeds the list size
    a_fcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= CNTW'(MAX_FLIPS)) else $error("flip count overflow");
    // a flip is only written while idle or at an add's finish
    a_flip_we: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_flip_we |-> (r_st == pse_pkg::ST_IDLE || r_st == pse_pkg::ST_FINISH))
        else $error("stray flip write");
    // divider is never restarted while busy
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div.busy || r_st == pse_pkg::ST_DIV_REM)
        else $error("divider restart");
    // probability never exceeds one
    a_prob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_probability <= 17'd65536) else $error("probability range");
    // r_add_pend follows finish of an add
    a_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_add_pend |-> r_st == pse_pkg::ST_OUT) else $error("add sequencing");
endmodule

/* test/periodic_state_estimator_core_tb.sv */
// Self-checking testbench for the periodic state estimator core.
`timescale 1ns / 1ps

module periodic_state_estimator_core_tb;

    localparam int NCOMP    = 16;
    localparam int NFLIPS   = 256;
    localparam int COS_BITS = 10;

    // ---------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ---------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_req_type = '0;
    logic [3:0]  i_entry_index = '0;
    logic [15:0] i_amplitude = '0;
    logic [15:0] i_phase = '0;
    logic [15:0] i_frequency = '0;
    logic [31:0] i_time_value = '0;
    logic        i_observation = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [16:0] o_probability;
    logic        o_state_bit;
    logic        o_list_full;
    logic        o_flip_added;

    periodic_state_estimator_core uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Generous limit: worst case is far below this even with all stalls.
    initial begin
        #50_000_000;
        $display("periodic_state_estimator_core: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------
    // Request / result beats
    // ---------------------------------------------------------------
    typedef struct {
        pse_pkg::t_req kind;
        logic [3:0]  idx;
        logic [15:0] amp;
        logic [15:0] ph;
        logic [15:0] fr;
        logic [31:0] tv;
        logic        obs;
    } t_request;

    typedef struct {
        logic [16:0] prob;
        logic        sbit;
        logic        full;
        logic        added;
    } t_estimate;

    typedef struct {
        t_request  rq;
        bit        typed;   // row carries a hand-written expected result
        t_estimate res;
    } t_stim_row;

    // ---------------------------------------------------------------
    // Predictor state: model registers, component table, flip list
    // ---------------------------------------------------------------
    int          cos_lut [1 << COS_BITS];
    logic [15:0] mean_level;
    logic [4:0]  comp_count;
    logic [31:0] obs_len;
    logic [15:0] comp_amp   [NCOMP];
    logic [15:0] comp_phase [NCOMP];
    logic [15:0] comp_freq  [NCOMP];
    logic [31:0] flips      [NFLIPS];
    int unsigned flip_cnt;

    t_estimate   pending_q[$];
    int          n_err = 0;
    int          n_results = 0;
    bit          quiet = 1'b0;     // no idling on either side this phase

    // Quarter-wave cosine, Taylor to x^10, Q30 in, Q15 out.
    function automatic int quarter_wave(logic [63:0] u30);
        logic [63:0] x, x2, h, tt;
        x  = (u30 * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        h  = (64'd1 << 30) - x2 / 90;
        h  = (64'd1 << 30) - ((x2 * h) >> 30) / 56;
        h  = (64'd1 << 30) - ((x2 * h) >> 30) / 30;
        h  = (64'd1 << 30) - ((x2 * h) >> 30) / 12;
        tt = ((x2 * h) >> 30) / 2;
        if (tt >= (64'd1 << 30)) return 0;
        return int'((((64'd1 << 30) - tt) + 64'd16384) >> 15);
    endfunction

    initial begin
        int q;
        logic [63:0] u;
        for (int k = 0; k < (1 << COS_BITS); k++) begin
            q = k >> (COS_BITS - 2);
            u = 64'(k & ((1 << (COS_BITS - 2)) - 1)) << (32 - COS_BITS);
            case (q)
                0: cos_lut[k] = quarter_wave(u);
                1: cos_lut[k] = -quarter_wave((64'd1 << 30) - u);
                2: cos_lut[k] = -quarter_wave(u);
                default: cos_lut[k] = quarter_wave((64'd1 << 30) - u);
            endcase
        end
    end

    // Probability at timestamp t, Q1.16 clamped to 0..65536.
    function automatic logic [16:0] prob_at(logic [31:0] t);
        longint      acc;
        logic [63:0] rem, frac;
        logic [15:0] ang;
        int          n;
        n   = (comp_count < NCOMP) ? int'(comp_count) : NCOMP;
        acc = (longint'(mean_level) - longint'(pse_pkg::LEVEL_BIAS)) * 16384;
        for (int i = 0; i < n; i++) begin
            frac = '0;
            if (obs_len != 0) begin
                rem  = (64'(comp_freq[i]) * 64'(t)) % 64'(obs_len);
                frac = (rem << 16) / 64'(obs_len);
            end
            ang = 16'(frac + 64'(comp_phase[i]));
            acc += longint'(comp_amp[i]) * longint'(cos_lut[ang >> (16 - COS_BITS)]);
        end
        if (acc <= 0) return 17'd0;
        if (acc >= (longint'(1) << 30)) return 17'd65536;
        return 17'((acc + 8192) >>> 14);
    endfunction

    // Apply one request to the predictor state and return its result beat.
    function automatic t_estimate advance_model(t_request r);
        t_estimate e;
        int unsigned pos;
        e = '{default: '0};
        case (r.kind)
            pse_pkg::REQ_LOAD_COMP: begin
                comp_amp[r.idx]   = r.amp;
                comp_phase[r.idx] = r.ph;
                comp_freq[r.idx]  = r.fr;
            end
            pse_pkg::REQ_LOAD_FLIP: begin
                if (flip_cnt < NFLIPS) begin
                    flips[flip_cnt] = r.tv;
                    flip_cnt++;
                end else begin
                    e.full = 1'b1;
                end
            end
            pse_pkg::REQ_QUERY: begin
                e.prob = prob_at(r.tv);
                pos = 0;
                while (pos < flip_cnt && !(r.tv < flips[pos])) pos++;
                e.sbit = (e.prob >= 17'd32768) ^ pos[0];
            end
            default: begin
                e.prob = prob_at(obs_len);
                e.sbit = (e.prob > 17'd32768) ^ flip_cnt[0];
                if (e.sbit != r.obs) begin
                    if (flip_cnt < NFLIPS) begin
                        flips[flip_cnt] = obs_len;
                        flip_cnt++;
                        e.added = 1'b1;
                    end else begin
                        e.full = 1'b1;
                    end
                end
                obs_len = obs_len + 32'd1;
            end
        endcase
        return e;
    endfunction

    // ---------------------------------------------------------------
    // APB register write: setup then access, driven at falling edges
    // ---------------------------------------------------------------
    task automatic write_reg(pse_pkg::t_reg r, logic [31:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = 4'(r) << 2;
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (r)
            pse_pkg::REG_MEAN_LEVEL: mean_level = val[15:0];
            pse_pkg::REG_COMP_COUNT: comp_count = val[4:0];
            default:                 obs_len    = val;
        endcase
    endtask

    // ---------------------------------------------------------------
    // Sender: optional gap, then hold the beat until accepted
    // ---------------------------------------------------------------
    task automatic send_request(t_request r, bit typed, t_estimate typed_res);
        int gap;
        t_estimate e;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req_type    = r.kind;
        i_entry_index = r.idx;
        i_amplitude   = r.amp;
        i_phase       = r.ph;
        i_frequency   = r.fr;
        i_time_value  = r.tv;
        i_observation = r.obs;
        i_valid       = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        e = advance_model(r);
        pending_q.push_back(typed ? typed_res : e);
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_valid = 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (5) @(negedge i_clk);
    endtask

    // Random request; flip points are kept mostly ascending so parity scans go deep.
    function automatic t_request random_request(int flip_pct);
        t_request    r;
        int          pick;
        logic [31:0] base;
        r.idx = 4'($urandom);
        r.amp = 16'($urandom);
        r.ph  = 16'($urandom);
        r.fr  = 16'($urandom);
        r.tv  = $urandom;
        r.obs = 1'($urandom);
        base  = (flip_cnt > 0) ? flips[flip_cnt - 1] : 32'd0;
        if (obs_len > base && obs_len - base < 32'd100000) base = obs_len;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            r.kind = pse_pkg::REQ_LOAD_COMP;
        end else if (pick < 10 + flip_pct) begin
            r.kind = pse_pkg::REQ_LOAD_FLIP;
            if ($urandom_range(0, 19) != 0) r.tv = base + $urandom_range(1, 500);
        end else if (pick < 10 + flip_pct + (90 - flip_pct) * 6 / 10) begin
            r.kind = pse_pkg::REQ_QUERY;
            case ($urandom_range(0, 3))
                0, 1: r.tv = $urandom_range(0, base + 1000);
                2:    r.tv = obs_len - $urandom_range(0, 50);
                default: ;
            endcase
        end else begin
            r.kind = pse_pkg::REQ_ADD;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off after 200 beats
    // ---------------------------------------------------------------
    int hold = 0;
    bit long_hold_done = 1'b0;

    always @(negedge i_clk) begin
        if (!long_hold_done && n_results == 200) begin
            long_hold_done = 1'b1;
            hold = 600;
        end
        if (hold > 0) begin
            hold--;
            i_ready = 1'b0;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
            i_ready = 1'b0;
        end else begin
            i_ready = 1'b1;
        end
    end

    // Result checker: each beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_estimate x;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (pending_q.size() == 0) begin
                $error("unexpected result beat: probability %0d", o_probability);
                n_err++;
            end else begin
                x = pending_q.pop_front();
                if (o_probability !== x.prob) begin
                    $error("probability: expected %0d, got %0d", x.prob, o_probability);
                    n_err++;
                end
                if (o_state_bit !== x.sbit) begin
                    $error("state_bit: expected %0d, got %0d", x.sbit, o_state_bit);
                    n_err++;
                end
                if (o_list_full !== x.full) begin
                    $error("list_full: expected %0d, got %0d", x.full, o_list_full);
                    n_err++;
                end
                if (o_flip_added !== x.added) begin
                    $error("flip_added: expected %0d, got %0d", x.added, o_flip_added);
                    n_err++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Directed rows: reset defaults (mean 0, no components, length 1),
    // so every probability is 0 and state bits follow the flip parity.
    // ---------------------------------------------------------------
    localparam t_estimate ZERO_RES = '{prob: 17'd0, sbit: 1'b0, full: 1'b0, added: 1'b0};

    t_stim_row directed [] = '{
        '{'{pse_pkg::REQ_QUERY, 4'h0, 16'h0, 16'h0, 16'h0, 32'h0, 1'b0}, 1, ZERO_RES},
        '{'{pse_pkg::REQ_QUERY, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1},
          1, ZERO_RES},
        '{'{pse_pkg::REQ_LOAD_COMP, 4'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0, 1'b0},
          1, ZERO_RES},
        '{'{pse_pkg::REQ_LOAD_COMP, 4'hF, 16'h0, 16'h0, 16'h0, 32'hFFFF_FFFF, 1'b1},
          1, ZERO_RES},
        '{'{pse_pkg::REQ_ADD, 4'h0, 16'h0, 16'h0, 16'h0, 32'h0, 1'b0}, 1, ZERO_RES},
        '{'{pse_pkg::REQ_LOAD_FLIP, 4'h3, 16'h1234, 16'h0, 16'h0, 32'h0, 1'b0}, 1, ZERO_RES},
        // flip point at 0: a query at 0 counts it, odd parity
        '{'{pse_pkg::REQ_QUERY, 4'h0, 16'h0, 16'h0, 16'h0, 32'h0, 1'b0}, 1,
          '{17'd0, 1'b1, 1'b0, 1'b0}},
        // add at length 2 predicts 1, observation 0 -> flip point stored
        '{'{pse_pkg::REQ_ADD, 4'h0, 16'h0, 16'h0, 16'h0, 32'h0, 1'b0}, 1,
          '{17'd0, 1'b1, 1'b0, 1'b1}},
        '{'{pse_pkg::REQ_ADD, 4'h0, 16'h0, 16'h0, 16'h0, 32'h0, 1'b1}, 0, ZERO_RES},
        '{'{pse_pkg::REQ_ADD, 4'h5, 16'hFFFF, 16'h0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1},
          0, ZERO_RES},
        '{'{pse_pkg::REQ_QUERY, 4'h0, 16'h0, 16'h0, 16'h0, 32'd1, 1'b0}, 0, ZERO_RES},
        '{'{pse_pkg::REQ_QUERY, 4'h0, 16'h0, 16'h0, 16'h0, 32'hFFFF_FFFF, 1'b0}, 0, ZERO_RES},
        '{'{pse_pkg::REQ_LOAD_FLIP, 4'h0, 16'h0, 16'h0, 16'h0, 32'd2, 1'b1}, 0, ZERO_RES},
        '{'{pse_pkg::REQ_QUERY, 4'h0, 16'h0, 16'h0, 16'h0, 32'd2, 1'b0}, 0, ZERO_RES}
    };

    // Random phases: mean, component count, initial length, beats, flip-load share.
    localparam int NPHASE = 10;
    logic [15:0] ph_mean  [NPHASE] = '{30000, 32768, 20000, 65535, 0,
                                       32768, 40000, 25000, 32768, 10000};
    logic [4:0]  ph_count [NPHASE] = '{0, 1, 3, 2, 4, 16, 2, 3, 16, 1};
    logic [31:0] ph_len   [NPHASE] = '{1000, 500, 1, 32'd4000000000, 77,
                                       100000, 65535, 32'hFFFF_FFFA, 123, 9};
    int          ph_items [NPHASE] = '{40, 45, 45, 35, 40, 25, 170, 60, 15, 40};
    int          ph_flip  [NPHASE] = '{20, 20, 20, 20, 20, 15, 88, 15, 20, 25};

    initial begin
        t_request r;
        mean_level = '0;
        comp_count = '0;
        obs_len    = 32'd1;
        flip_cnt   = 0;
        for (int i = 0; i < NCOMP; i++) begin
            comp_amp[i]   = '0;
            comp_phase[i] = '0;
            comp_freq[i]  = '0;
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[n])
            send_request(directed[n].rq, directed[n].typed, directed[n].res);
        drain();

        for (int p = 0; p < NPHASE; p++) begin
            quiet = (p == 2);
            write_reg(pse_pkg::REG_MEAN_LEVEL, 32'(ph_mean[p]));
            write_reg(pse_pkg::REG_COMP_COUNT, 32'(ph_count[p]));
            write_reg(pse_pkg::REG_INIT_LEN, ph_len[p]);
            // fill every component slot before any phase uses components
            if (p == 0) begin
                for (int k = 0; k < NCOMP; k++) begin
                    r = random_request(0);
                    r.kind = pse_pkg::REQ_LOAD_COMP;
                    r.idx  = 4'(k);
                    send_request(r, 0, ZERO_RES);
                end
            end
            for (int n = 0; n < ph_items[p]; n++)
                send_request(random_request(ph_flip[p]), 0, ZERO_RES);
            // sender waits here until every result is back
            drain();
        end
        quiet = 1'b0;

        repeat (20) @(posedge i_clk);
        if (n_err == 0 && pending_q.size() == 0) begin
            $display("periodic_state_estimator_core: match");
        end else begin
            $display("periodic_state_estimator_core: mismatch");
        end
        $finish;
    end

endmodule

/* periodic_state_estimator_core.f */
design/pse_pkg.sv
design/pse_ram.sv
design/pse_div.sv
design/periodic_state_estimator_core.sv
test/periodic_state_estimator_core_tb.sv
